// File: design/assert_macros.svh
// Assertion macros shared by the RTL. They compile away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define U8_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8flf: assertion failed");
// Next-cycle implication, disabled while reset is low
`define U8_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8flf: assertion failed");
`else
`define U8_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define U8_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/u8flf_pkg.sv
`timescale 1ns / 1ps

package u8flf_pkg;

    // Byte store geometry: at most BUF_DEPTH-1 bytes are held
    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = ADDR_W;
    localparam int KEPT_W    = 6;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Mode codes of an input word
    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_POLL   = 1'b1;

    // UTF-8 byte classes
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_TAG   = 8'hF0;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD_LIMIT  = 8'hF5;
    localparam logic [7:0] LOW6_MASK   = 8'h3F;

    // No-boundary flush kicks in this close to full
    localparam int NEAR_FULL = 4;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0]        out_first;
        logic [7:0]        out_second;
        logic              two_bytes;
        logic              reencoded;
        logic              last;
        logic [KEPT_W-1:0] kept_count;
    } out_word_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic       is_poll;
        logic [7:0] data_byte;
    } cmd_t;

    // Ring pointer add; both operands are below BUF_DEPTH
    function automatic logic [ADDR_W-1:0] ptr_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ADDR_W + 1)'(BUF_DEPTH)) begin
            s = s - (ADDR_W + 1)'(BUF_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic is_cont(input logic [7:0] c);
        return (c & CONT_MASK) == CONT_TAG;
    endfunction

    // Sequence length implied by a lead byte; bad leads count as one
    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] n;
        if (c < ASCII_LIMIT) begin
            n = 3'd1;
        end else if ((c & LEAD2_MASK) == LEAD2_TAG) begin
            n = 3'd2;
        end else if ((c & LEAD3_MASK) == LEAD3_TAG) begin
            n = 3'd3;
        end else if ((c & LEAD4_MASK) == LEAD4_TAG) begin
            n = 3'd4;
        end else begin
            n = 3'd1;
        end
        return n;
    endfunction

endpackage

// File: design/u8flf_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module u8flf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (re) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/u8flf_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Front end: takes input words, classifies them and queues commands
module u8flf_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  u8flf_pkg::in_word_t s_word,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output u8flf_pkg::cmd_t     cmd
);

    u8flf_pkg::cmd_t                 queue_reg [u8flf_pkg::QUEUE_DEPTH];
    u8flf_pkg::cmd_t                 cmd_in;
    logic [u8flf_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [u8flf_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [u8flf_pkg::QPTR_W:0]      count_reg, count_next;
    logic                            push, pop;

    // Classify: poll or append
    always_comb begin
        cmd_in.is_poll   = (s_word.mode == u8flf_pkg::MODE_POLL);
        cmd_in.data_byte = s_word.data_byte;
    end

    assign s_ready   = (count_reg != (u8flf_pkg::QPTR_W + 1)'(u8flf_pkg::QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = queue_reg[rd_ptr_reg];

    // Queue pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + u8flf_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + u8flf_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (u8flf_pkg::QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (u8flf_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    `U8_ASSERT_NXT(a_q_push_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + (u8flf_pkg::QPTR_W + 1)'(1))
    `U8_ASSERT_NXT(a_q_pop_shrinks, aclk, aresetn, pop && !push, count_reg == $past(count_reg) - (u8flf_pkg::QPTR_W + 1)'(1))

endmodule

// File: design/u8flf_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Back end: owns the byte ring, runs appends and the three poll walks
module u8flf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  u8flf_pkg::cmd_t      cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    output u8flf_pkg::out_word_t m_word
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN_RD  = 3'd1;
    localparam logic [2:0] ST_SCAN_CHK = 3'd2;
    localparam logic [2:0] ST_VAL_RD   = 3'd3;
    localparam logic [2:0] ST_VAL_CHK  = 3'd4;
    localparam logic [2:0] ST_EMIT_RD  = 3'd5;
    localparam logic [2:0] ST_EMIT_OUT = 3'd6;

    localparam int CW = u8flf_pkg::CNT_W;

    logic [2:0]                     state_reg, state_next;
    logic [u8flf_pkg::ADDR_W-1:0]   head_reg, head_next;
    logic [CW-1:0]                  fill_reg, fill_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  safe_reg, safe_next;
    logic [1:0]                     extra_reg, extra_next;
    logic                           valid_reg, valid_next;
    logic                           m_valid_reg, m_valid_next;
    u8flf_pkg::out_word_t           out_reg, out_next;
    logic                           out_load;

    logic                           ram_we, ram_re;
    logic [u8flf_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [7:0]                     ram_rdata;

    logic [CW-1:0]                  idx_m1;
    logic [CW:0]                    idx_p1;
    logic [CW:0]                    lead_end;
    logic [CW:0]                    near_sum;
    logic [CW-1:0]                  safe_cand;
    logic [CW-1:0]                  safe_fin;
    logic                           scan_done;
    logic                           bad;
    logic [1:0]                     ext;
    logic                           expand;
    logic [7:0]                     c;

    u8flf_ram #(
        .WIDTH (8),
        .DEPTH (u8flf_pkg::BUF_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (cmd.data_byte),
        .re      (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign idx_m1    = idx_reg - CW'(1);
    assign idx_p1    = {1'b0, idx_reg} + (CW + 1)'(1);
    assign c         = ram_rdata;
    assign ram_waddr = u8flf_pkg::ptr_add(head_reg, fill_reg);
    assign ram_raddr = u8flf_pkg::ptr_add(head_reg,
                                          (state_reg == ST_SCAN_RD) ? idx_m1 : idx_reg);
    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_word    = out_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        safe_next    = safe_reg;
        extra_next   = extra_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        out_load     = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        scan_done    = 1'b0;
        safe_cand    = '0;
        bad          = 1'b0;
        ext          = extra_reg;
        lead_end     = {1'b0, idx_m1} + (CW + 1)'(u8flf_pkg::seq_len(c));
        near_sum     = {1'b0, fill_reg} + (CW + 1)'(u8flf_pkg::NEAR_FULL);
        expand       = !valid_reg && c[7];

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.is_poll) begin
                        if (fill_reg != '0) begin
                            idx_next   = fill_reg;
                            state_next = ST_SCAN_RD;
                        end
                    end else if (fill_reg != CW'(u8flf_pkg::BUF_DEPTH - 1)) begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + CW'(1);
                    end
                end
            end

            ST_SCAN_RD: begin
                ram_re     = 1'b1;
                state_next = ST_SCAN_CHK;
            end

            // Walk back over trailing continuation bytes to the last lead
            ST_SCAN_CHK: begin
                if (u8flf_pkg::is_cont(c)) begin
                    if (idx_m1 == '0) begin
                        scan_done = 1'b1;
                    end else begin
                        idx_next   = idx_m1;
                        state_next = ST_SCAN_RD;
                    end
                end else begin
                    scan_done = 1'b1;
                    safe_cand = (lead_end <= {1'b0, fill_reg}) ? fill_reg : idx_m1;
                end
            end

            ST_VAL_RD: begin
                ram_re     = 1'b1;
                state_next = ST_VAL_CHK;
            end

            // Strict UTF-8 check, one byte per visit
            ST_VAL_CHK: begin
                if (extra_reg != 2'd0) begin
                    if (!u8flf_pkg::is_cont(c)) begin
                        bad = 1'b1;
                    end else begin
                        ext = extra_reg - 2'd1;
                    end
                end else if (c < u8flf_pkg::ASCII_LIMIT) begin
                    ext = 2'd0;
                end else if (c < u8flf_pkg::LEAD2_MIN) begin
                    bad = 1'b1;
                end else if (c < u8flf_pkg::LEAD3_TAG) begin
                    ext = 2'd1;
                end else if (c < u8flf_pkg::LEAD4_TAG) begin
                    ext = 2'd2;
                end else if (c < u8flf_pkg::LEAD_LIMIT) begin
                    ext = 2'd3;
                end else begin
                    bad = 1'b1;
                end

                if (bad) begin
                    valid_next = 1'b0;
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end else if (idx_p1 == {1'b0, safe_reg}) begin
                    valid_next = (ext == 2'd0);
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    extra_next = ext;
                    idx_next   = idx_p1[CW-1:0];
                    state_next = ST_VAL_RD;
                end
            end

            ST_EMIT_RD: begin
                ram_re     = 1'b1;
                state_next = ST_EMIT_OUT;
            end

            // Emit one word, re-encoding from Latin-1 when the chunk failed
            ST_EMIT_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load           = 1'b1;
                    m_valid_next       = 1'b1;
                    out_next.out_first = expand
                        ? (u8flf_pkg::LEAD2_TAG | {6'd0, c[7:6]}) : c;
                    out_next.out_second = expand
                        ? (u8flf_pkg::CONT_TAG | (c & u8flf_pkg::LOW6_MASK)) : 8'd0;
                    out_next.two_bytes  = expand;
                    out_next.reencoded  = !valid_reg;
                    out_next.last       = (idx_p1 == {1'b0, safe_reg});
                    out_next.kept_count = u8flf_pkg::KEPT_W'(fill_reg - safe_reg);
                    if (idx_p1 == {1'b0, safe_reg}) begin
                        head_next  = u8flf_pkg::ptr_add(head_reg, safe_reg);
                        fill_next  = fill_reg - safe_reg;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_p1[CW-1:0];
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Boundary search finished: apply the near-full fallback
        safe_fin = safe_cand;
        if (safe_cand == '0 && near_sum >= (CW + 1)'(u8flf_pkg::BUF_DEPTH)) begin
            safe_fin = fill_reg;
        end
        if (scan_done) begin
            if (safe_fin == '0) begin
                state_next = ST_IDLE;
            end else begin
                safe_next  = safe_fin;
                idx_next   = '0;
                extra_next = 2'd0;
                valid_next = 1'b1;
                state_next = ST_VAL_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Walk and output payload
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        safe_reg  <= safe_next;
        extra_reg <= extra_next;
        valid_reg <= valid_next;
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    `U8_ASSERT_IMP(a_we_only_append, aclk, aresetn, ram_we, state_reg == ST_IDLE && !cmd.is_poll)
    `U8_ASSERT_NXT(a_last_ends_flush, aclk, aresetn, out_load && out_next.last, state_reg == ST_IDLE)
    `U8_ASSERT_NXT(a_empty_poll_idle, aclk, aresetn, cmd_valid && cmd_ready && cmd.is_poll && fill_reg == '0, state_reg == ST_IDLE)
    `U8_ASSERT_IMP(a_emit_in_range, aclk, aresetn, state_reg == ST_EMIT_OUT, idx_reg < safe_reg)

endmodule

// File: design/utf8_chunk_flush_latin1_fallback.sv
`timescale 1ns / 1ps

// UTF-8 chunk flusher with Latin-1 fallback. Append words (mode 0) store one
// byte in a 64-entry ring, at most 63 held, extras dropped; the executor takes
// each append without leaving idle, so a steady byte stream is accepted one word
// per clock until the 4-word command queue absorbing a poll's busy time fills.
// A poll (mode 1) makes up to three walks, one after another, over the single
// read port of the byte RAM: a backward scan over trailing continuation bytes
// to the last lead byte, a forward strict-UTF-8 check over the flushed prefix
// (stopping at the first error), and the emit walk, which produces one result
// word per flushed byte and stalls while the output register is held. An
// invalid chunk comes out re-encoded from Latin-1; last marks the final word
// and kept_count gives the bytes left behind. No clearing pass is needed after
// reset.
module utf8_chunk_flush_latin1_fallback (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  u8flf_pkg::in_word_t  s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output u8flf_pkg::out_word_t m_word
);

    logic            cmd_valid;
    logic            cmd_ready;
    u8flf_pkg::cmd_t cmd;

    u8flf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    u8flf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

// File: dv/tb_utf8_chunk_flush_latin1_fallback.sv
`timescale 1ns / 1ps

// Mirrors the byte store, predicts the words of every flush and checks them in order
class flush_scoreboard;
    logic [7:0]           held [u8flf_pkg::BUF_DEPTH];
    logic [6:0]           fill_level = '0;
    u8flf_pkg::out_word_t awaited [$];

    int mismatches     = 0;
    int words_checked  = 0;
    int appends        = 0;
    int drops          = 0;
    int polls          = 0;
    int flushes        = 0;
    int latin1_chunks  = 0;
    int forced_flushes = 0;

    // Longest prefix ending on a whole sequence, by length alone
    function int whole_seq_prefix(int len);
        int i;
        int n;
        logic [7:0] c;
        i = len;
        while (i > 0 && (held[i-1] & u8flf_pkg::CONT_MASK) == u8flf_pkg::CONT_TAG) i--;
        if (i == 0) return 0;
        c = held[i-1];
        if (c < u8flf_pkg::ASCII_LIMIT) n = 1;
        else if ((c & u8flf_pkg::LEAD2_MASK) == u8flf_pkg::LEAD2_TAG) n = 2;
        else if ((c & u8flf_pkg::LEAD3_MASK) == u8flf_pkg::LEAD3_TAG) n = 3;
        else if ((c & u8flf_pkg::LEAD4_MASK) == u8flf_pkg::LEAD4_TAG) n = 4;
        else n = 1;   // bad lead stands alone
        return ((i - 1) + n <= len) ? len : i - 1;
    endfunction

    // Strict check: lead range plus the right count of continuations
    function bit is_strict_utf8(int len);
        int i;
        int extra;
        logic [7:0] c;
        i = 0;
        while (i < len) begin
            c = held[i];
            i++;
            if (c < u8flf_pkg::ASCII_LIMIT) continue;
            if (c < u8flf_pkg::LEAD2_MIN) return 1'b0;
            else if (c < u8flf_pkg::LEAD3_TAG) extra = 1;
            else if (c < u8flf_pkg::LEAD4_TAG) extra = 2;
            else if (c < u8flf_pkg::LEAD_LIMIT) extra = 3;
            else return 1'b0;
            while (extra > 0) begin
                if (i >= len || (held[i] & u8flf_pkg::CONT_MASK) != u8flf_pkg::CONT_TAG)
                    return 1'b0;
                i++;
                extra--;
            end
        end
        return 1'b1;
    endfunction

    // Returns 0 for a word the block ignores (dropped byte, empty poll)
    function bit note_input(u8flf_pkg::in_word_t w);
        int used;
        int cut;
        int kept;
        bit ok;
        logic [7:0] b;
        u8flf_pkg::out_word_t e;
        if (w.mode == u8flf_pkg::MODE_APPEND) begin
            appends++;
            if (fill_level >= u8flf_pkg::BUF_DEPTH - 1) begin
                drops++;
                return 1'b0;
            end
            held[fill_level] = w.data_byte;
            fill_level++;
            return 1'b1;
        end
        polls++;
        used = fill_level;
        if (used == 0) return 1'b0;
        cut = whole_seq_prefix(used);
        // no boundary but close to full: take everything
        if (cut == 0 && used + u8flf_pkg::NEAR_FULL >= u8flf_pkg::BUF_DEPTH) begin
            cut = used;
            forced_flushes++;
        end
        if (cut == 0) return 1'b1;
        kept = used - cut;
        ok = is_strict_utf8(cut);
        flushes++;
        if (!ok) latin1_chunks++;
        for (int k = 0; k < cut; k++) begin
            b = held[k];
            e.two_bytes  = !ok && (b >= u8flf_pkg::ASCII_LIMIT);
            e.out_first  = e.two_bytes ? (u8flf_pkg::LEAD2_TAG | (b >> 6)) : b;
            e.out_second = e.two_bytes ? (u8flf_pkg::CONT_TAG | (b & u8flf_pkg::LOW6_MASK))
                                       : 8'h00;
            e.reencoded  = !ok;
            e.last       = (k == cut - 1);
            e.kept_count = u8flf_pkg::KEPT_W'(kept);
            awaited.push_back(e);
        end
        for (int k = 0; k < kept; k++) held[k] = held[k + cut];
        fill_level = 7'(kept);
        return 1'b1;
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            if (mismatches < 10)
                $display("word %0d: %s expected %0h, got %0h", words_checked, field, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(u8flf_pkg::out_word_t got);
        u8flf_pkg::out_word_t want;
        if (awaited.size() == 0) begin
            if (mismatches < 10)
                $display("result word with nothing pending: first %02h second %02h last %0b",
                         got.out_first, got.out_second, got.last);
            mismatches++;
            return;
        end
        want = awaited.pop_front();
        words_checked++;
        compare_field("out_first", want.out_first, got.out_first);
        compare_field("out_second", want.out_second, got.out_second);
        compare_field("two_bytes", want.two_bytes, got.two_bytes);
        compare_field("reencoded", want.reencoded, got.reencoded);
        compare_field("last", want.last, got.last);
        compare_field("kept_count", want.kept_count, got.kept_count);
    endfunction

    function void check_drained();
        if (awaited.size() > 0) begin
            $display("%0d predicted result words never came out", awaited.size());
            mismatches++;
        end
    endfunction
endclass

module tb_utf8_chunk_flush_latin1_fallback;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    u8flf_pkg::in_word_t  s_word  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    u8flf_pkg::out_word_t m_word;

    flush_scoreboard sb = new();
    int items_sent = 0;

    always #1 aclk = ~aclk;

    utf8_chunk_flush_latin1_fallback dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    // Idle cycles before the next word; none during quiet stretches
    function automatic int pick_idle(bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // Valid is only lowered when a gap follows, so it never drops and rises in one step
    task automatic send_word(input u8flf_pkg::in_word_t w);
        int gap;
        gap = pick_idle(((items_sent / 32) % 3) == 1);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        void'(sb.note_input(w));
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        u8flf_pkg::in_word_t w;
        w.mode      = u8flf_pkg::MODE_APPEND;
        w.data_byte = b;
        send_word(w);
    endtask

    task automatic send_poll();
        u8flf_pkg::in_word_t w;
        w.mode      = u8flf_pkg::MODE_POLL;
        w.data_byte = 8'($urandom);   // don't care on a poll
        send_word(w);
    endtask

    // One character of n bytes; broken spoils or drops its tail, split polls mid-character
    task automatic send_char(input int n, input bit broken, input bit split);
        logic [7:0] b;
        case (n)
            1:       b = 8'($urandom_range(8'h00, 8'h7F));
            2:       b = 8'($urandom_range(8'hC2, 8'hDF));
            3:       b = 8'($urandom_range(8'hE0, 8'hEF));
            default: b = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        send_byte(b);
        for (int j = 1; j < n; j++) begin
            if (split && j == 1) send_poll();
            b = 8'($urandom_range(8'h80, 8'hBF));
            if (broken && j == n - 1) begin
                if ($urandom_range(0, 1) == 0) break;
                b = 8'($urandom_range(0, 255));
            end
            send_byte(b);
        end
    endtask

    // Push the store toward or past full, then poll
    task automatic fill_store(input bit conts_only, input int target);
        int need;
        need = target - int'(sb.fill_level);
        for (int j = 0; j < need; j++) begin
            if (conts_only) send_byte(8'($urandom_range(8'h80, 8'hBF)));
            else if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
            else send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        send_poll();
    endtask

    // Result side: random stalls, quiet stretches, check each word taken
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = pick_idle(((sb.words_checked / 40) % 3) == 2);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            sb.check_result(m_word);
        end
    end

    // Stimulus
    initial begin
        int kind;
        int chars;
        int bad_at;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty poll, byte extremes, bad lead, incomplete and orphan sequences
        send_poll();
        send_byte(8'h00);
        send_poll();
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_poll();
        send_byte(8'hC3);
        send_byte(8'hA9);
        send_poll();
        send_byte(8'hE2);
        send_byte(8'h82);
        send_poll();          // no boundary yet, nothing flushed
        send_byte(8'hAC);
        send_poll();
        send_byte(8'h80);
        send_poll();          // continuation bytes alone have no boundary
        send_byte(8'h41);
        send_poll();
        send_byte(8'hC0);
        send_byte(8'h80);
        send_poll();          // overlong lead, re-encoded
        send_byte(8'hF0);
        send_byte(8'h9F);
        send_byte(8'h98);
        send_byte(8'h80);
        send_poll();

        // overflow with continuation bytes: drops, then a whole-store flush
        fill_store(1'b1, u8flf_pkg::BUF_DEPTH + 2);

        // random scenarios, mostly well-formed text
        while (items_sent < 220) begin
            kind = $urandom_range(0, 15);
            if (kind <= 8 || kind == 12 || kind == 13) begin
                chars  = $urandom_range(1, 8);
                bad_at = (kind >= 12) ? $urandom_range(0, chars - 1) : -1;
                for (int c = 0; c < chars; c++)
                    send_char($urandom_range(1, 4), c == bad_at, $urandom_range(0, 7) == 0);
                if ($urandom_range(0, 3) != 0) send_poll();
            end else if (kind <= 11) begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
                send_poll();
            end else begin
                fill_store(kind == 15,
                           $urandom_range(u8flf_pkg::BUF_DEPTH - u8flf_pkg::NEAR_FULL,
                                          u8flf_pkg::BUF_DEPTH + 1));
            end
        end
        send_poll();
        s_valid <= 1'b0;

        // drain, then leave room for any stray word
        while (sb.awaited.size() > 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        sb.check_drained();

        $display("covered %0d appends (%0d dropped while full) and %0d polls, %0d flushes",
                 sb.appends, sb.drops, sb.polls, sb.flushes);
        $display("%0d result words checked; %0d chunks re-encoded, %0d flushed without boundary",
                 sb.words_checked, sb.latin1_chunks, sb.forced_flushes);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/u8flf_pkg.sv
design/u8flf_ram.sv
design/u8flf_front.sv
design/u8flf_back.sv
design/utf8_chunk_flush_latin1_fallback.sv
dv/tb_utf8_chunk_flush_latin1_fallback.sv
